// ===== sv/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hash.
// Used by sha256_sched, sha256_round and sha256_stream_hash_top.
package sha256_pkg;

  localparam int LEN_BITS = 61;   // byte counter width, 32 to 61
  localparam int ROUNDS   = 64;
  localparam int BLOCK_BYTES = 64;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] hash_t;   // word 0 is the most significant
  typedef logic [5:0] round_idx_t;
  typedef logic [5:0] fill_t;

  localparam hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam fill_t LEN_START = fill_t'(56);

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic shift_byte;   // push one byte into the block
    logic step;         // advance the message schedule by one word
  } sched_ctl_t;

  typedef struct packed {
    logic load;         // copy the hash words into the working variables
    logic step;         // run one compression round
  } round_ctl_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== sv/sha256_sched.sv =====
// Block buffer and rolling message schedule: a 16-word window that takes
// bytes in while filling and steps one schedule word per round. Uses sha256_pkg.
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  input  logic [7:0]             byte_in,
  output sha256_pkg::word_t      w_out
);
  import sha256_pkg::*;

  word_t win [16];
  word_t w_new;

  assign w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w_out = win[0];

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      // whole block moves up by one byte, new byte lands at the bottom
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], byte_in};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

// ===== sv/sha256_round.sv =====
// Compression round unit: eight working variables, one round per cycle while step is high.
// Uses sha256_pkg for the round constants and sigma functions.
module sha256_round (
  input  logic                   clk,
  input  sha256_pkg::round_ctl_t ctl,
  input  sha256_pkg::round_idx_t round_idx,
  input  sha256_pkg::word_t      w_in,
  input  sha256_pkg::hash_t      hash_in,
  output sha256_pkg::hash_t      v_out
);
  import sha256_pkg::*;

  hash_t v;
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + big_sigma1(v[4]) + ch + ROUND_K[round_idx] + w_in;
  assign t2  = big_sigma0(v[0]) + maj;
  assign v_out = v;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= hash_in;
    end else if (ctl.step) begin
      v <= {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    end
  end

endmodule

// ===== sv/sha256_stream_hash_top.sv =====
// SHA-256 stream hash: sequencer, hash words, length counter and digest register.
// A byte item is pushed in its accepting cycle; a byte that completes a 64-byte block
// then runs a compression (load, 64 rounds at one round per cycle in sha256_round, hash add).
// An end item pads one byte per cycle outside its compressions and runs one or two
// compressions before the digest shows. in_ready is low while busy.
// Reset (rst, synchronous) loads the initial hash words and clears the counters.
module sha256_stream_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_w01,
  output logic [63:0] digest_w23,
  output logic [63:0] digest_w45,
  output logic [63:0] digest_w67
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_PADZ, S_LEN, S_LOAD, S_COMP, S_ADD, S_FIN
  } state_t;

  state_t                state;
  state_t                ret;
  hash_t                 hash;
  hash_t                 v;
  fill_t                 fill;
  logic [LEN_BITS-1:0]   total;
  round_idx_t            round_idx;
  logic                  accept;
  logic [63:0]           len_bits;
  logic [63:0]           len_sh;
  logic [7:0]            sched_byte;
  sched_ctl_t            sched_ctl;
  round_ctl_t            round_ctl;
  word_t                 w;
  logic                  push;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign len_bits = 64'(total) << 3;
  assign len_sh   = len_bits >> {~fill[2:0], 3'b000};

  always_comb begin
    sched_byte = 8'h00;
    push       = 1'b0;
    case (state)
      S_IDLE: begin
        sched_byte = data_byte;
        push       = accept && has_byte;
      end
      S_PAD80: begin
        sched_byte = PAD_MARK;
        push       = 1'b1;
      end
      S_PADZ:  push = (fill != LEN_START);
      S_LEN: begin
        sched_byte = len_sh[7:0];
        push       = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign sched_ctl.shift_byte = push;
  assign sched_ctl.step       = (state == S_COMP);
  assign round_ctl.load       = (state == S_LOAD);
  assign round_ctl.step       = (state == S_COMP);

  sha256_sched u_sched (
    .clk     (clk),
    .ctl     (sched_ctl),
    .byte_in (sched_byte),
    .w_out   (w)
  );

  sha256_round u_round (
    .clk       (clk),
    .ctl       (round_ctl),
    .round_idx (round_idx),
    .w_in      (w),
    .hash_in   (hash),
    .v_out     (v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      hash      <= HASH_IV;
      fill      <= '0;
      total     <= '0;
      round_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      if (push) begin
        fill <= fill + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (has_byte) begin
              total <= total + 1'b1;
            end
            if (has_byte && (&fill)) begin
              state <= S_LOAD;
              ret   <= end_of_message ? S_PAD80 : S_IDLE;
            end else if (end_of_message) begin
              state <= S_PAD80;
            end
          end
        end
        S_PAD80: begin
          ret   <= S_PADZ;
          state <= (&fill) ? S_LOAD : S_PADZ;
        end
        S_PADZ: begin
          if (fill == LEN_START) begin
            state <= S_LEN;
          end else if (&fill) begin
            ret   <= S_PADZ;
            state <= S_LOAD;
          end
        end
        S_LEN: begin
          if (&fill) begin
            ret   <= S_FIN;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          round_idx <= '0;
          state     <= S_COMP;
        end
        S_COMP: begin
          round_idx <= round_idx + 1'b1;
          if (&round_idx) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          state <= ret;
        end
        S_FIN: begin
          // hold until the digest register is free
          if (!out_valid || out_ready) begin
            digest_w01 <= {hash[0], hash[1]};
            digest_w23 <= {hash[2], hash[3]};
            digest_w45 <= {hash[4], hash[5]};
            digest_w67 <= {hash[6], hash[7]};
            out_valid  <= 1'b1;
            hash       <= HASH_IV;
            total      <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
